>>> design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator: the layout of
// one block table entry, the status codes and the list terminator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int OFFSET_W = 16;
	localparam int SIZE_W   = 16;
	localparam int LINK_W   = 7;
	localparam int COUNT_W  = 7;
	localparam int ADDR_W   = 32;
	localparam int REQ_W    = 17;
	localparam int STATUS_W = 2;

	// Link value that ends the address-ordered block list.
	localparam logic [LINK_W-1:0] LINK_NONE = 7'd127;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FIT   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FREE     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// One block table entry: header offset from the arena base, data bytes,
	// free flag and the index of the next block in address order.
	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [SIZE_W-1:0]   size;
		logic                free;
		logic [LINK_W-1:0]   next;
	} blk_t;

endpackage

>>> design/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit allocator over one arena of address-ordered blocks with headers.
// ----------------------------------------------------------------------------
// The block keeps a table of up to MAX_BLOCKS blocks in one single-port-write
// memory with a registered read, linked in address order. An allocate item
// walks the list from the first block, one list entry per clock cycle, and
// takes the first free block that is large enough; a block that exceeds the
// request by more than one header is split while the table has room; the
// remainder becomes a new block at the table end, and a split state then
// rewrites the found block. A free item scans the table in index order, one
// entry per cycle, for the block whose data starts at free_address. An item
// goes from idle through the walk or scan, any split state and the finish
// state, paced by the single memory read port; a free outside the arena goes
// straight to finish. The input side is stalled while an item is in
// work; a finished result sits in the output register, and the next item is
// accepted while it waits there. A result that finds the output register
// still full and stalled holds the sequencer until the register drains.
// Neighboring free blocks are never merged. No clearing pass is needed after
// reset: only the first entry has a reset value, which a single flag supplies
// until that entry is first written.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top #(
	parameter int ARENA_BYTES  = 65536,
	parameter int HEADER_BYTES = 20,
	parameter int MAX_BLOCKS   = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write channel (arena base address).
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ffba_pkg::ADDR_W-1:0]    cfg_data,
	// Request items.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [ffba_pkg::REQ_W-1:0]     request_size,
	input  logic [ffba_pkg::ADDR_W-1:0]    free_address,
	// Result items.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ffba_pkg::ADDR_W-1:0]    data_address,
	output logic [ffba_pkg::STATUS_W-1:0]  status
);

	localparam int IW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0; // waiting for an item
	localparam logic [2:0] S_WALK  = 3'd1; // allocate: walk the block list
	localparam logic [2:0] S_SRCH  = 3'd2; // free: scan the table
	localparam logic [2:0] S_SPLIT = 3'd3; // allocate: rewrite the split block
	localparam logic [2:0] S_FIN   = 3'd4; // hand the result to the output register

	localparam ffba_pkg::blk_t RESET_ENTRY = '{
		offset: '0,
		size:   ffba_pkg::SIZE_W'(ARENA_BYTES - HEADER_BYTES),
		free:   1'b1,
		next:   ffba_pkg::LINK_NONE
	};

	logic [2:0]                         state_q;
	logic [ffba_pkg::ADDR_W-1:0]        base_q;
	logic [ffba_pkg::COUNT_W-1:0]       used_q;
	logic                               init0_q;
	logic [ffba_pkg::REQ_W-1:0]         want_q;
	logic [ffba_pkg::ADDR_W-1:0]        dist_q;
	logic [IW-1:0]                      hit_idx_q;
	logic [ffba_pkg::OFFSET_W-1:0]      hit_off_q;
	logic [ffba_pkg::ADDR_W-1:0]        res_addr_q;
	logic [ffba_pkg::STATUS_W-1:0]      res_status_q;
	logic                               out_valid_q;
	logic [ffba_pkg::ADDR_W-1:0]        out_addr_q;
	logic [ffba_pkg::STATUS_W-1:0]      out_status_q;

	// Block table memory.
	ffba_pkg::blk_t                     mem_q [MAX_BLOCKS];
	ffba_pkg::blk_t                     rdata_q;
	logic [IW-1:0]                      rd_idx_q;
	logic [IW-1:0]                      rd_addr;
	logic                               we;
	logic [IW-1:0]                      waddr;
	ffba_pkg::blk_t                     wdata;

	ffba_pkg::blk_t                     ent;
	logic                               take;
	logic                               fits;
	logic                               split;
	logic                               walk_end;
	logic                               match;
	logic                               scan_end;
	logic [ffba_pkg::COUNT_W-1:0]       idx_inc;
	logic [ffba_pkg::REQ_W:0]           split_off;
	logic [ffba_pkg::REQ_W:0]           split_size;
	logic [ffba_pkg::ADDR_W-1:0]        hit_addr;
	logic                               out_free;

	assign cfg_ready    = 1'b1;
	assign in_stall     = (state_q != S_IDLE);
	assign take         = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign data_address = out_addr_q;
	assign status       = out_status_q;
	assign out_free     = !out_valid_q || !out_stall;

	// The first entry reads as its reset value until it is first written.
	assign ent = (rd_idx_q == '0 && !init0_q) ? RESET_ENTRY : rdata_q;

	// Allocate: fit test, split test and the end of the list.
	assign fits  = ent.free && ({1'b0, ent.size} >= want_q);
	assign split = ((ffba_pkg::REQ_W+1)'(ent.size) >
			(ffba_pkg::REQ_W+1)'(want_q) + (ffba_pkg::REQ_W+1)'(HEADER_BYTES))
			&& (used_q < ffba_pkg::COUNT_W'(MAX_BLOCKS));
	assign walk_end = (ent.next >= used_q);

	assign split_off  = (ffba_pkg::REQ_W+1)'(ent.offset) +
			(ffba_pkg::REQ_W+1)'(HEADER_BYTES) + (ffba_pkg::REQ_W+1)'(want_q);
	assign split_size = (ffba_pkg::REQ_W+1)'(ent.size) -
			(ffba_pkg::REQ_W+1)'(HEADER_BYTES) - (ffba_pkg::REQ_W+1)'(want_q);
	assign hit_addr   = base_q + ffba_pkg::ADDR_W'(ent.offset) +
			ffba_pkg::ADDR_W'(HEADER_BYTES);

	// Free: data start compare and the end of the scan.
	assign match    = (ffba_pkg::ADDR_W'(ent.offset) +
			ffba_pkg::ADDR_W'(HEADER_BYTES)) == dist_q;
	assign idx_inc  = ffba_pkg::COUNT_W'(rd_idx_q) + ffba_pkg::COUNT_W'(1);
	assign scan_end = (idx_inc >= used_q);

	// Read address and the single write port of the table.
	always_comb begin
		rd_addr = '0;
		we      = 1'b0;
		waddr   = rd_idx_q;
		wdata   = ent;
		unique case (state_q)
			S_WALK: begin
				rd_addr = ent.next[IW-1:0];
				if (fits) begin
					we = 1'b1;
					if (split) begin
						// The remainder becomes a new free block at the table end.
						waddr       = used_q[IW-1:0];
						wdata.offset = split_off[ffba_pkg::OFFSET_W-1:0];
						wdata.size   = split_size[ffba_pkg::SIZE_W-1:0];
						wdata.free   = 1'b1;
						wdata.next   = ent.next;
					end else begin
						wdata.free = 1'b0;
					end
				end
			end
			S_SRCH: begin
				rd_addr = idx_inc[IW-1:0];
				if (match && !ent.free) begin
					we         = 1'b1;
					wdata.free = 1'b1;
				end
			end
			S_SPLIT: begin
				we          = 1'b1;
				waddr       = hit_idx_q;
				wdata.offset = hit_off_q;
				wdata.size   = want_q[ffba_pkg::SIZE_W-1:0];
				wdata.free   = 1'b0;
				wdata.next   = used_q;
			end
			S_IDLE, S_FIN: begin
				rd_addr = '0;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q  <= mem_q[rd_addr];
		rd_idx_q <= rd_addr;
	end

	// Sequencer, table bookkeeping and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			base_q       <= '0;
			used_q       <= ffba_pkg::COUNT_W'(1);
			init0_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			res_addr_q   <= '0;
			res_status_q <= ffba_pkg::ST_OK;
			hit_idx_q    <= '0;
			hit_off_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
			if (we && waddr == '0) begin
				init0_q <= 1'b1;
			end
			// A new result loads the output register; otherwise an accepted
			// result leaves it empty.
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						if (op == ffba_pkg::OP_ALLOC) begin
							state_q <= S_WALK;
						end else if (free_address - base_q >=
								ffba_pkg::ADDR_W'(ARENA_BYTES)) begin
							res_addr_q   <= '0;
							res_status_q <= ffba_pkg::ST_BAD_ADDR;
							state_q      <= S_FIN;
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_WALK: begin
					if (fits) begin
						res_addr_q   <= hit_addr;
						res_status_q <= ffba_pkg::ST_OK;
						hit_idx_q    <= rd_idx_q;
						hit_off_q    <= ent.offset;
						state_q      <= split ? S_SPLIT : S_FIN;
					end else if (walk_end) begin
						res_addr_q   <= '0;
						res_status_q <= ffba_pkg::ST_NO_FIT;
						state_q      <= S_FIN;
					end
				end
				S_SPLIT: begin
					used_q  <= used_q + ffba_pkg::COUNT_W'(1);
					state_q <= S_FIN;
				end
				S_SRCH: begin
					res_addr_q <= '0;
					if (match) begin
						res_status_q <= ent.free ? ffba_pkg::ST_FREE : ffba_pkg::ST_OK;
						state_q      <= S_FIN;
					end else if (scan_end) begin
						res_status_q <= ffba_pkg::ST_BAD_ADDR;
						state_q      <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request fields and the result payload need no reset.
	always_ff @(posedge clk) begin
		if (take) begin
			want_q <= request_size;
			dist_q <= free_address - base_q;
		end
		if (state_q == S_FIN && out_free) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

endmodule
